/* design/mmx_pkg.sv */
// Shared types and constants of the multi-source audio mixer.
package mmx_pkg;

	localparam int MAX_SOURCES = 4;
	localparam int BUF_DEPTH   = 64;

	localparam int SRC_W     = 2;
	localparam int ACT_W     = $clog2(MAX_SOURCES + 1);
	localparam int PTR_W     = $clog2(BUF_DEPTH);
	localparam int FILL_W    = PTR_W + 1;
	localparam int MEM_DEPTH = MAX_SOURCES * BUF_DEPTH;
	localparam int MEM_AW    = SRC_W + PTR_W;

	localparam int SMP_W  = 16;
	localparam int GAIN_W = 16;
	localparam int Q_W    = 24;
	localparam int FRAC_W = 19;
	localparam int PROD_W = 2 * Q_W;
	localparam int ACC_W  = 30;

	localparam int CNT_W     = 3;
	localparam int BANK_W    = 64;
	localparam int THR_W     = 6;
	localparam int CAP_W     = 16;
	localparam int CFG_W     = 64;
	localparam int CFG_IDX_W = 3;

	// scaler: q = round(|s| * gain * 32 / 32767), via floor((|s|*gain*32 + 16383) / 32767)
	localparam int SC_PROD_W = SMP_W + GAIN_W;
	localparam int SC_N_W    = SC_PROD_W + 5 + 1;
	localparam int SC_DIV_SH = 15;
	localparam int SC_QM_W   = SC_N_W - SC_DIV_SH;
	localparam int SC_R_W    = SC_DIV_SH + 2;
	localparam logic [SC_N_W-1:0] SC_BIAS = SC_N_W'(16383);
	localparam logic [SC_R_W-1:0] SC_DIV  = SC_R_W'(32767);

	localparam logic signed [ACC_W-1:0]  Q_MAX    = ACC_W'(8388607);
	localparam logic signed [ACC_W-1:0]  Q_MIN    = -ACC_W'(8388608);
	localparam logic signed [Q_W-1:0]    Q_ONE    = Q_W'(524288);
	localparam logic signed [Q_W-1:0]    Q_NONE   = -Q_W'(524288);
	localparam logic signed [PROD_W-1:0] PROD_RND = PROD_W'(262144);
	localparam logic signed [SMP_W-1:0]  PCM_MAX  = 16'sh7FFF;
	localparam logic signed [SMP_W-1:0]  PCM_MIN  = 16'sh8000;

	localparam logic [CNT_W-1:0]  RST_SOURCE_COUNT = CNT_W'(1);
	localparam logic [BANK_W-1:0] RST_GAINS        = 64'h4000_4000_4000_4000;
	localparam logic [THR_W-1:0]  RST_THRESHOLD    = THR_W'(32);
	localparam logic [CAP_W-1:0]  RST_CAPACITY     = 16'h8000;

	localparam logic OP_PUSH  = 1'b0;
	localparam logic OP_DRAIN = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SOURCE_COUNT    = 3'd0,
		CFG_LEFT_GAINS      = 3'd1,
		CFG_RIGHT_GAINS     = 3'd2,
		CFG_MIX_THRESHOLD   = 3'd3,
		CFG_OUTPUT_CAPACITY = 3'd4
	} mmx_cfg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCALE,
		ST_CHECK,
		ST_RD,
		ST_MUL,
		ST_ACC,
		ST_EMIT,
		ST_SLIDE
	} mmx_state_t;

	typedef struct packed {
		logic                    opcode;
		logic [SRC_W-1:0]        source;
		logic signed [SMP_W-1:0] sample;
		logic                    block_end;
	} mmx_in_t;

	typedef struct packed {
		logic signed [SMP_W-1:0] mixed_sample;
		logic                    run_last;
	} mmx_out_t;

endpackage

/* design/mmx_scale.sv */
// Three-stage sample scaler: sample * gain * 32 / 32767, rounded half away from zero.
module mmx_scale (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic signed [mmx_pkg::SMP_W-1:0]   sample,
	input  logic [mmx_pkg::GAIN_W-1:0]         gain,
	output logic                               done,
	output logic signed [mmx_pkg::Q_W-1:0]     q
);

	logic                               v_s1, v_s2, v_s3;
	logic                               neg_s1, neg_s2;
	logic [mmx_pkg::SC_PROD_W-1:0]      prod_s1;
	logic [mmx_pkg::SC_N_W-1:0]         n_s2;
	logic [mmx_pkg::SC_QM_W-1:0]        q0_s2;
	logic signed [mmx_pkg::Q_W-1:0]     q_s3;

	logic [mmx_pkg::SMP_W-1:0]          mag;
	logic [mmx_pkg::SC_N_W-1:0]         n_c;
	logic [mmx_pkg::SC_N_W-1:0]         est_c;
	logic [mmx_pkg::SC_N_W-1:0]         rem_c;
	logic [mmx_pkg::SC_R_W-1:0]         r_c;
	logic [mmx_pkg::SC_QM_W-1:0]        qmag_c;
	logic [mmx_pkg::Q_W-1:0]            qext_c;

	assign mag = sample[mmx_pkg::SMP_W-1] ? mmx_pkg::SMP_W'(-sample) : sample;

	// 1/32767 = 2^-15 * (1 + 2^-15 + 2^-30 + ...); estimate is q or q-1
	assign n_c   = {1'b0, prod_s1, 5'b0} + mmx_pkg::SC_BIAS;
	assign est_c = n_c + (n_c >> mmx_pkg::SC_DIV_SH) + (n_c >> (2 * mmx_pkg::SC_DIV_SH));

	assign rem_c  = n_s2 - {q0_s2, mmx_pkg::SC_DIV_SH'(0)} + mmx_pkg::SC_N_W'(q0_s2);
	assign r_c    = rem_c[mmx_pkg::SC_R_W-1:0];
	assign qmag_c = q0_s2 + mmx_pkg::SC_QM_W'(r_c >= mmx_pkg::SC_DIV);
	assign qext_c = mmx_pkg::Q_W'(qmag_c);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= mmx_pkg::SC_PROD_W'(mag * gain);
		neg_s1  <= sample[mmx_pkg::SMP_W-1];
		n_s2    <= n_c;
		q0_s2   <= est_c[mmx_pkg::SC_N_W-1:mmx_pkg::SC_DIV_SH];
		neg_s2  <= neg_s1;
		q_s3    <= neg_s2 ? -$signed(qext_c) : $signed(qext_c);
	end

	assign done = v_s3;
	assign q    = q_s3;

endmodule

/* design/multi_source_audio_mixer.sv */
// Top level of the multi-source audio mixer (Z = A + B - AB) with per-source sample memory.
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+------------------------------------------
//  in      | input     | in_valid / in_ready      | in_data  : opcode, source, sample, block_end
//  out     | output    | out_valid / out_ready    | out_data : mixed_sample, run_last
//  cfg     | input     | cfg_we (no wait)         | cfg_index, cfg_wdata
//
// A push passes acceptance and the three-stage scaler; the scaled Q4.19 value is then
// written to the sample memory if its source is active and not full. A drain clears the
// output fill. On block end come the min/room check and, if a run starts, per mixed
// sample a memory read, 24x24 multiply and accumulate for each active source plus an
// emit, then a slide of the ring heads; the loop over one read port sets the pace.
// Reset clears fills, heads, parity, output fill and loop control and loads the configuration
// defaults; memory and datapath registers are not cleared. An output transaction not yet
// taken holds the emit state; the next input is taken once the current one has finished,
// and a last result can still wait in the output register while new input is accepted.
module multi_source_audio_mixer (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  mmx_pkg::mmx_in_t                  in_data,
	output logic                              out_valid,
	input  logic                              out_ready,
	output mmx_pkg::mmx_out_t                 out_data,
	input  logic                              cfg_we,
	input  logic [mmx_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [mmx_pkg::CFG_W-1:0]         cfg_wdata
);

	// configuration
	logic [mmx_pkg::CNT_W-1:0]   src_cnt_q;
	logic [mmx_pkg::BANK_W-1:0]  lgain_q;
	logic [mmx_pkg::BANK_W-1:0]  rgain_q;
	logic [mmx_pkg::THR_W-1:0]   thr_q;
	logic [mmx_pkg::CAP_W-1:0]   cap_q;

	// per-source ring buffers: head pointer and fill count
	logic [mmx_pkg::FILL_W-1:0]  fill_q [mmx_pkg::MAX_SOURCES];
	logic [mmx_pkg::PTR_W-1:0]   head_q [mmx_pkg::MAX_SOURCES];
	logic                        parity_q;
	logic [mmx_pkg::CAP_W-1:0]   ofill_q;

	mmx_pkg::mmx_state_t         st_q, st_d;

	// latched push
	logic [mmx_pkg::SRC_W-1:0]   src_q;
	logic                        blk_end_q;
	logic                        store_q;

	// mix loop
	logic [mmx_pkg::FILL_W-1:0]  run_q;
	logic [mmx_pkg::PTR_W-1:0]   j_q;
	logic [mmx_pkg::SRC_W-1:0]   i_q;
	logic signed [mmx_pkg::Q_W-1:0]    z_q;
	logic signed [mmx_pkg::Q_W-1:0]    x_q;
	logic signed [mmx_pkg::PROD_W-1:0] prod_q;

	logic                        out_valid_q;
	mmx_pkg::mmx_out_t           out_data_q;

	// sample memory
	logic [mmx_pkg::Q_W-1:0]     buf_mem [mmx_pkg::MEM_DEPTH];
	logic [mmx_pkg::Q_W-1:0]     mem_rdata;
	logic [mmx_pkg::MEM_AW-1:0]  mem_raddr;
	logic [mmx_pkg::MEM_AW-1:0]  mem_waddr;
	logic                        mem_we;

	// scaler
	logic                        sc_start;
	logic                        sc_done;
	logic signed [mmx_pkg::Q_W-1:0] sc_q;
	logic [mmx_pkg::BANK_W-1:0]  bank;
	logic [mmx_pkg::GAIN_W-1:0]  gain;

	logic                        in_acc;
	logic                        out_load;
	logic [mmx_pkg::ACT_W-1:0]   active;
	logic [mmx_pkg::FILL_W-1:0]  min_fill;
	logic [mmx_pkg::CAP_W-1:0]   room;
	logic [mmx_pkg::FILL_W-1:0]  run_new;
	logic                        mix_go;
	logic                        src_last;
	logic                        run_end;
	logic                        push_store;

	logic signed [mmx_pkg::PROD_W-1:0] prod_rnd;
	logic signed [mmx_pkg::PROD_W-1:0] prod_sh;
	logic signed [mmx_pkg::ACC_W-1:0]  acc_sum;
	logic signed [mmx_pkg::Q_W-1:0]    z_next;

	logic [mmx_pkg::Q_W-1:0]     zmag;
	logic [mmx_pkg::Q_W+14:0]    pcm_scaled;
	logic [mmx_pkg::SMP_W-1:0]   pcm_mag;
	logic signed [mmx_pkg::SMP_W-1:0] pcm;

	assign in_acc = in_valid && in_ready;

	assign active = (src_cnt_q > mmx_pkg::CNT_W'(mmx_pkg::MAX_SOURCES))
		? mmx_pkg::ACT_W'(mmx_pkg::MAX_SOURCES) : mmx_pkg::ACT_W'(src_cnt_q);

	// gain bank follows the parity before this push toggles it
	assign bank = parity_q ? lgain_q : rgain_q;
	assign gain = bank[mmx_pkg::GAIN_W * in_data.source +: mmx_pkg::GAIN_W];

	assign push_store = (mmx_pkg::ACT_W'(in_data.source) < active)
		&& (fill_q[in_data.source] < mmx_pkg::FILL_W'(mmx_pkg::BUF_DEPTH));

	assign sc_start = in_acc && (in_data.opcode == mmx_pkg::OP_PUSH);

	mmx_scale u_scale (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sc_start),
		.sample (in_data.sample),
		.gain   (gain),
		.done   (sc_done),
		.q      (sc_q)
	);

	// smallest fill over active sources
	always_comb begin
		min_fill = fill_q[0];
		for (int k = 1; k < mmx_pkg::MAX_SOURCES; k++) begin
			if (mmx_pkg::ACT_W'(k) < active && fill_q[k] < min_fill) begin
				min_fill = fill_q[k];
			end
		end
	end

	assign room    = (ofill_q < cap_q) ? cap_q - ofill_q : '0;
	assign run_new = (room < mmx_pkg::CAP_W'(min_fill)) ? room[mmx_pkg::FILL_W-1:0] : min_fill;
	assign mix_go  = (active != '0) && (min_fill > mmx_pkg::FILL_W'(thr_q)) && (room != '0);

	assign src_last = ({1'b0, i_q} == active - 1'b1);
	assign run_end  = ({1'b0, j_q} == run_q - 1'b1);

	// Z + x - round(Z*x), saturated to Q4.19 range
	assign prod_rnd = prod_q + mmx_pkg::PROD_RND;
	assign prod_sh  = prod_rnd >>> mmx_pkg::FRAC_W;
	assign acc_sum  = {{(mmx_pkg::ACC_W - mmx_pkg::Q_W){z_q[mmx_pkg::Q_W-1]}}, z_q}
		+ {{(mmx_pkg::ACC_W - mmx_pkg::Q_W){x_q[mmx_pkg::Q_W-1]}}, x_q}
		- prod_sh[mmx_pkg::ACC_W-1:0];

	always_comb begin
		if (acc_sum > mmx_pkg::Q_MAX) begin
			z_next = mmx_pkg::Q_MAX[mmx_pkg::Q_W-1:0];
		end else if (acc_sum < mmx_pkg::Q_MIN) begin
			z_next = mmx_pkg::Q_MIN[mmx_pkg::Q_W-1:0];
		end else begin
			z_next = acc_sum[mmx_pkg::Q_W-1:0];
		end
	end

	// Q4.19 to int16: clip at +/-1.0, else trunc(z * 32767 / 2^19) toward zero
	assign zmag       = z_q[mmx_pkg::Q_W-1] ? mmx_pkg::Q_W'(-z_q) : z_q;
	assign pcm_scaled = {zmag, 15'b0} - (mmx_pkg::Q_W + 15)'(zmag);
	assign pcm_mag    = pcm_scaled[mmx_pkg::FRAC_W +: mmx_pkg::SMP_W];

	always_comb begin
		if (z_q >= mmx_pkg::Q_ONE) begin
			pcm = mmx_pkg::PCM_MAX;
		end else if (z_q < mmx_pkg::Q_NONE) begin
			pcm = mmx_pkg::PCM_MIN;
		end else if (z_q[mmx_pkg::Q_W-1]) begin
			pcm = -$signed(pcm_mag);
		end else begin
			pcm = $signed(pcm_mag);
		end
	end

	assign mem_waddr = {src_q, head_q[src_q] + fill_q[src_q][mmx_pkg::PTR_W-1:0]};
	assign mem_raddr = {i_q, head_q[i_q] + j_q};

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= mmx_pkg::ST_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	// next state and strobes
	always_comb begin
		st_d     = st_q;
		in_ready = 1'b0;
		mem_we   = 1'b0;
		out_load = 1'b0;
		case (st_q)
			mmx_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid && in_data.opcode == mmx_pkg::OP_PUSH) begin
					st_d = mmx_pkg::ST_SCALE;
				end
			end
			mmx_pkg::ST_SCALE: begin
				if (sc_done) begin
					mem_we = store_q;
					st_d   = blk_end_q ? mmx_pkg::ST_CHECK : mmx_pkg::ST_IDLE;
				end
			end
			mmx_pkg::ST_CHECK: begin
				st_d = mix_go ? mmx_pkg::ST_RD : mmx_pkg::ST_IDLE;
			end
			mmx_pkg::ST_RD: begin
				st_d = mmx_pkg::ST_MUL;
			end
			mmx_pkg::ST_MUL: begin
				st_d = mmx_pkg::ST_ACC;
			end
			mmx_pkg::ST_ACC: begin
				st_d = src_last ? mmx_pkg::ST_EMIT : mmx_pkg::ST_RD;
			end
			mmx_pkg::ST_EMIT: begin
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					st_d     = run_end ? mmx_pkg::ST_SLIDE : mmx_pkg::ST_RD;
				end
			end
			mmx_pkg::ST_SLIDE: begin
				st_d = mmx_pkg::ST_IDLE;
			end
			default: begin
				st_d = mmx_pkg::ST_IDLE;
			end
		endcase
	end

	// sample memory, one write and one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			buf_mem[mem_waddr] <= sc_q;
		end
		mem_rdata <= buf_mem[mem_raddr];
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_cnt_q <= mmx_pkg::RST_SOURCE_COUNT;
			lgain_q   <= mmx_pkg::RST_GAINS;
			rgain_q   <= mmx_pkg::RST_GAINS;
			thr_q     <= mmx_pkg::RST_THRESHOLD;
			cap_q     <= mmx_pkg::RST_CAPACITY;
		end else if (cfg_we) begin
			case (cfg_index)
				mmx_pkg::CFG_SOURCE_COUNT:    src_cnt_q <= cfg_wdata[mmx_pkg::CNT_W-1:0];
				mmx_pkg::CFG_LEFT_GAINS:      lgain_q   <= cfg_wdata[mmx_pkg::BANK_W-1:0];
				mmx_pkg::CFG_RIGHT_GAINS:     rgain_q   <= cfg_wdata[mmx_pkg::BANK_W-1:0];
				mmx_pkg::CFG_MIX_THRESHOLD:   thr_q     <= cfg_wdata[mmx_pkg::THR_W-1:0];
				mmx_pkg::CFG_OUTPUT_CAPACITY: cap_q     <= cfg_wdata[mmx_pkg::CAP_W-1:0];
				default: ;
			endcase
		end
	end

	// buffer bookkeeping and loop control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < mmx_pkg::MAX_SOURCES; k++) begin
				fill_q[k] <= '0;
				head_q[k] <= '0;
			end
			parity_q    <= 1'b0;
			ofill_q     <= '0;
			src_q       <= '0;
			blk_end_q   <= 1'b0;
			store_q     <= 1'b0;
			run_q       <= '0;
			j_q         <= '0;
			i_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_acc) begin
				if (in_data.opcode == mmx_pkg::OP_DRAIN) begin
					ofill_q <= '0;
				end else begin
					src_q     <= in_data.source;
					blk_end_q <= in_data.block_end;
					store_q   <= push_store;
					parity_q  <= in_data.block_end ? 1'b0 : ~parity_q;
				end
			end
			if (mem_we) begin
				fill_q[src_q] <= fill_q[src_q] + 1'b1;
			end
			if (st_q == mmx_pkg::ST_CHECK) begin
				run_q <= run_new;
				j_q   <= '0;
				i_q   <= '0;
			end
			if (st_q == mmx_pkg::ST_ACC && !src_last) begin
				i_q <= i_q + 1'b1;
			end
			if (out_load && !run_end) begin
				j_q <= j_q + 1'b1;
				i_q <= '0;
			end
			if (st_q == mmx_pkg::ST_SLIDE) begin
				for (int k = 0; k < mmx_pkg::MAX_SOURCES; k++) begin
					if (mmx_pkg::ACT_W'(k) < active) begin
						head_q[k] <= head_q[k] + run_q[mmx_pkg::PTR_W-1:0];
						fill_q[k] <= fill_q[k] - run_q;
					end
				end
				ofill_q <= ofill_q + mmx_pkg::CAP_W'(run_q);
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (st_q == mmx_pkg::ST_CHECK || out_load) begin
			z_q <= '0;
		end else if (st_q == mmx_pkg::ST_ACC) begin
			z_q <= z_next;
		end
		if (st_q == mmx_pkg::ST_MUL) begin
			x_q    <= $signed(mem_rdata);
			prod_q <= z_q * $signed(mem_rdata);
		end
		if (out_load) begin
			out_data_q.mixed_sample <= pcm;
			out_data_q.run_last     <= run_end;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// fill counts stay within the ring depth
	for (genvar g = 0; g < mmx_pkg::MAX_SOURCES; g++) begin : g_fill_chk
		a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
			fill_q[g] <= mmx_pkg::FILL_W'(mmx_pkg::BUF_DEPTH))
			else $error("fill count above ring depth");
	end

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> fill_q[src_q] < mmx_pkg::FILL_W'(mmx_pkg::BUF_DEPTH))
		else $error("write into a full ring");

	a_rd_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == mmx_pkg::ST_RD) |-> (run_q != '0 && {1'b0, j_q} < run_q))
		else $error("mix read outside the run");

	a_emit_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == mmx_pkg::ST_EMIT && out_valid_q && !out_ready)
		|=> (st_q == mmx_pkg::ST_EMIT && $stable(z_q) && $stable(j_q)))
		else $error("emit lost while output stalled");

	a_slide_fits: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == mmx_pkg::ST_SLIDE) |-> run_q <= fill_q[0])
		else $error("run longer than buffered data");

endmodule
